/* rtl/tre_pkg.sv */
// ----------------------------------------------------------------------------
// TFTP receive engine package
// Shared constants, codes and the types passed between the engine's parts.
// ----------------------------------------------------------------------------
`default_nettype none

package tre_pkg;

  localparam int BLOCK_BYTES = 512;

  // Payload length is compared with one extra bit so a block size up to 2047 fits.
  localparam int LEN_W  = 10;
  localparam int LENX_W = 11;

  // Action codes.
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_PACKET  = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  // Packet opcodes.
  localparam logic [15:0] OP_DATA  = 16'h0003;
  localparam logic [15:0] OP_ERROR = 16'h0005;

  // Result status codes.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_STARTED  = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_ACCEPTED = 3'd3;
  localparam logic [2:0] ST_LAST     = 3'd4;
  localparam logic [2:0] ST_RETRY    = 3'd5;
  localparam logic [2:0] ST_ABORT    = 3'd6;
  localparam logic [2:0] ST_PEER_ERR = 3'd7;

  localparam logic [3:0] MAX_RETRIES_RST = 4'd10;

  // Classified event as it travels through the queue.
  typedef struct packed {
    logic        is_start;
    logic        is_packet;
    logic        is_timeout;
    logic        is_data;
    logic        is_error;
    logic        len_ok;
    logic        len_full;
    logic [15:0] block;
  } evt_t;

  // One result item.
  typedef struct packed {
    logic [15:0] peer_error_code;
    logic [2:0]  status;
    logic        store_payload;
    logic [15:0] ack_block;
    logic        send_ack;
  } res_t;

endpackage

`default_nettype wire

/* rtl/tftp_receive_engine.sv */
// out_tvalid rises once an event has passed through the queue register and
// then through the back end's result register.
// Throughput: one event per cycle while out_tready is high; the two-entry
// queue holds events while the output stalls.
// Reset (rst_n low, synchronous): queue and output emptied, transfer idle,
// expected block and retry count zero, max_retries back to 10.
// ----------------------------------------------------------------------------
// TFTP receive engine
// Lock-step TFTP receive control: front classifier, event queue, back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tftp_receive_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,     // max_retries
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] action, [17:2] pkt_opcode, [33:18] pkt_block, [43:34] payload_len
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] send_ack, [16:1] ack_block, [17] store_payload, [20:18] status,
  // [36:21] peer_error_code
  output logic [39:0]      out_tdata
);

  tre_pkg::evt_t evt_in;
  tre_pkg::evt_t evt_q;
  tre_pkg::res_t res;
  logic          q_valid;
  logic          q_pop;

  tre_front u_front (
    .action      (in_tdata[1:0]),
    .pkt_opcode  (in_tdata[17:2]),
    .pkt_block   (in_tdata[33:18]),
    .payload_len (in_tdata[43:34]),
    .evt         (evt_in)
  );

  tre_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid),
    .push_data  (evt_in),
    .push_ready (in_tready),
    .pop        (q_pop),
    .pop_data   (evt_q),
    .pop_valid  (q_valid)
  );

  tre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .evt_valid (q_valid),
    .evt       (evt_q),
    .evt_pop   (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {3'b000, res.peer_error_code, res.status, res.store_payload,
                      res.ack_block, res.send_ack};

endmodule

`default_nettype wire

/* rtl/tre_front.sv */
// ----------------------------------------------------------------------------
// TFTP receive engine front end
// Decodes the action and classifies the packet header independent of state.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_front (
  input  wire logic [1:0]          action,
  input  wire logic [15:0]         pkt_opcode,
  input  wire logic [15:0]         pkt_block,
  input  wire logic [9:0]          payload_len,
  output tre_pkg::evt_t            evt
);

  logic [tre_pkg::LENX_W-1:0] len_x;
  logic [tre_pkg::LENX_W-1:0] blk_bytes;

  assign len_x     = {1'b0, payload_len};
  assign blk_bytes = tre_pkg::LENX_W'(tre_pkg::BLOCK_BYTES);

  always_comb begin
    evt.is_start   = (action == tre_pkg::ACT_START);
    evt.is_packet  = (action == tre_pkg::ACT_PACKET);
    evt.is_timeout = (action == tre_pkg::ACT_TIMEOUT);
    evt.is_data    = (pkt_opcode == tre_pkg::OP_DATA);
    evt.is_error   = (pkt_opcode == tre_pkg::OP_ERROR);
    evt.len_ok     = (len_x <= blk_bytes);
    evt.len_full   = (len_x == blk_bytes);
    evt.block      = pkt_block;
  end

endmodule

`default_nettype wire

/* rtl/tre_queue.sv */
// ----------------------------------------------------------------------------
// TFTP receive engine event queue
// Two-entry FIFO of classified events between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  tre_pkg::evt_t      push_data,
  output logic               push_ready,
  input  wire logic          pop,
  output tre_pkg::evt_t      pop_data,
  output logic               pop_valid
);

  tre_pkg::evt_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/tre_back.sv */
// ----------------------------------------------------------------------------
// TFTP receive engine back end
// Holds the transfer state, executes one event per cycle unless its result is stalled, registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_wdata,
  input  wire logic          evt_valid,
  input  tre_pkg::evt_t      evt,
  output logic               evt_pop,
  output logic               res_valid,
  output tre_pkg::res_t      res,
  input  wire logic          res_ready
);

  logic          active_r, active_nxt;
  logic [15:0]   expected_r, expected_nxt;
  logic [3:0]    retry_r, retry_nxt;
  logic [3:0]    max_retries_r;
  logic          valid_r;
  tre_pkg::res_t res_r;
  tre_pkg::res_t res_nxt;
  logic [3:0]    retry_inc;

  assign evt_pop   = evt_valid && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;
  assign retry_inc = retry_r + 4'd1;

  always_comb begin
    active_nxt   = active_r;
    expected_nxt = expected_r;
    retry_nxt    = retry_r;
    res_nxt      = '0;
    res_nxt.status = tre_pkg::ST_IDLE;
    if (evt.is_start) begin
      res_nxt.send_ack = 1'b1;
      res_nxt.status   = tre_pkg::ST_STARTED;
      active_nxt       = 1'b1;
      expected_nxt     = 16'd1;
      retry_nxt        = 4'd0;
    end else if (evt.is_packet && active_r) begin
      if (evt.is_error) begin
        active_nxt              = 1'b0;
        res_nxt.status          = tre_pkg::ST_PEER_ERR;
        res_nxt.peer_error_code = evt.block;
      end else if (!evt.is_data || evt.block != expected_r || !evt.len_ok) begin
        res_nxt.status = tre_pkg::ST_IGNORED;
      end else begin
        res_nxt.store_payload = 1'b1;
        res_nxt.send_ack      = 1'b1;
        res_nxt.ack_block     = expected_r;
        expected_nxt          = expected_r + 16'd1;
        retry_nxt             = 4'd0;
        if (evt.len_full) begin
          res_nxt.status = tre_pkg::ST_ACCEPTED;
        end else begin
          active_nxt     = 1'b0;
          res_nxt.status = tre_pkg::ST_LAST;
        end
      end
    end else if (evt.is_timeout && active_r) begin
      retry_nxt = retry_inc;
      if (retry_inc >= max_retries_r) begin
        active_nxt     = 1'b0;
        res_nxt.status = tre_pkg::ST_ABORT;
      end else begin
        res_nxt.status = tre_pkg::ST_RETRY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      expected_r    <= 16'd0;
      retry_r       <= 4'd0;
      max_retries_r <= tre_pkg::MAX_RETRIES_RST;
      valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_retries_r <= cfg_wdata;
      end
      if (evt_pop) begin
        active_r   <= active_nxt;
        expected_r <= expected_nxt;
        retry_r    <= retry_nxt;
        valid_r    <= 1'b1;
      end else if (res_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire
